// ===== hw/rtl/stick_direction_autorepeat_core_defines.svh =====
// Assertion helpers for the core RTL file.
`ifndef STICK_DIRECTION_AUTOREPEAT_CORE_DEFINES_SVH
`define STICK_DIRECTION_AUTOREPEAT_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SDA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/stkdir_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package stkdir_pkg;

  // Field widths
  localparam int AXIS_W     = 16;
  localparam int TICKS_W    = 16;
  localparam int DEADZONE_W = 15;
  localparam int DELAY_W    = 24;
  localparam int HELD_W     = 32;
  localparam int DIR_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Stream widths, rounded up to whole bytes
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  // Register reset values
  localparam logic [DEADZONE_W-1:0] DEADZONE_RST        = 15'd7849;
  localparam logic [DELAY_W-1:0]    FIRST_DELAY_RST     = 24'd500;
  localparam logic [DELAY_W-1:0]    REPEAT_INTERVAL_RST = 24'd250;

  // Numpad direction coding
  localparam logic [DIR_W-1:0] DIR_NEUTRAL = 4'd5;
  localparam logic [DIR_W-1:0] DIR_STEP_X  = 4'd1;
  localparam logic [DIR_W-1:0] DIR_STEP_Y  = 4'd3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADZONE        = 2'd0,
    CFG_FIRST_DELAY     = 2'd1,
    CFG_REPEAT_INTERVAL = 2'd2
  } cfg_reg_t;

  // One result item, last field in the lowest bits
  typedef struct packed {
    logic             down_event;
    logic             up_event;
    logic             right_event;
    logic             left_event;
    logic             down_held;
    logic             up_held;
    logic             right_held;
    logic             left_held;
    logic             press_event;
    logic [DIR_W-1:0] direction_code;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/stick_direction_autorepeat_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "stick_direction_autorepeat_core_defines.svh"
// Stick direction decoder with typematic auto-repeat. Each input transfer carries one
// stick sample and the ticks elapsed since the previous one; each produces exactly one
// result: the numpad direction code (5 neutral), the four held flags, and a press event
// that fires on a direction change, again once the held time exceeds first_delay, then
// each time it exceeds repeat_interval. The block takes one sample per clock cycle while the
// result stream is not stalled; a result passes through the input register, then the result
// register, before it is offered. The rate is set by the held-time accumulate and threshold
// compare, a single combinational pass. Configuration writes are taken at any time but must only
// be issued while no sample is in flight.
module stick_direction_autorepeat_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Configuration write port
  input  wire logic                                cfg_wr_en,
  input  wire logic [stkdir_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [stkdir_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Sample stream
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // [15:0] axis_x, [31:16] axis_y, [47:32] elapsed_ticks
  input  wire logic [stkdir_pkg::IN_TDATA_W-1:0]   s_tdata,
  // Result stream
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // [3:0] direction_code, [4] press_event, [5] left_held, [6] right_held,
  // [7] up_held, [8] down_held, [9] left_event, [10] right_event,
  // [11] up_event, [12] down_event, [15:13] zero
  output logic [stkdir_pkg::OUT_TDATA_W-1:0]       m_tdata
);
  import stkdir_pkg::*;

  // Configuration registers
  logic [DEADZONE_W-1:0] deadzone;
  logic [DELAY_W-1:0]    first_delay;
  logic [DELAY_W-1:0]    repeat_interval;

  // Input register
  logic                  in_valid;
  logic [AXIS_W-1:0]     axis_x;
  logic [AXIS_W-1:0]     axis_y;
  logic [TICKS_W-1:0]    elapsed_ticks;

  // Repeat state
  logic [HELD_W-1:0]     held_time;
  logic                  repeating;
  logic [DIR_W-1:0]      last_direction;

  // Result register
  result_t               result;

  // Combinational single pass
  logic                  out_load;
  logic                  x_neg, x_pos, y_neg, y_pos;
  logic [AXIS_W:0]       x_mag, y_mag;
  logic [DIR_W-1:0]      dir;
  logic [HELD_W:0]       held_sum;
  logic [HELD_W-1:0]     held_sat;
  logic [DELAY_W-1:0]    threshold;
  logic                  press;
  logic [HELD_W-1:0]     held_time_next;
  logic                  repeating_next;
  result_t               result_next;

  // Handshake: the input register drains into the result register
  assign out_load = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || out_load;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone        <= DEADZONE_RST;
      first_delay     <= FIRST_DELAY_RST;
      repeat_interval <= REPEAT_INTERVAL_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DEADZONE:        deadzone        <= cfg_data[DEADZONE_W-1:0];
        CFG_FIRST_DELAY:     first_delay     <= cfg_data[DELAY_W-1:0];
        CFG_REPEAT_INTERVAL: repeat_interval <= cfg_data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      axis_x        <= s_tdata[15:0];
      axis_y        <= s_tdata[31:16];
      elapsed_ticks <= s_tdata[47:32];
    end
  end

  // Deadzone test; the most negative sample has magnitude 32768
  always_comb begin
    x_mag = axis_x[AXIS_W-1] ? ((AXIS_W+1)'(1) << AXIS_W) - {1'b0, axis_x} : {1'b0, axis_x};
    y_mag = axis_y[AXIS_W-1] ? ((AXIS_W+1)'(1) << AXIS_W) - {1'b0, axis_y} : {1'b0, axis_y};
    x_neg = axis_x[AXIS_W-1]  && (x_mag > (AXIS_W+1)'(deadzone));
    x_pos = !axis_x[AXIS_W-1] && (x_mag > (AXIS_W+1)'(deadzone));
    y_neg = axis_y[AXIS_W-1]  && (y_mag > (AXIS_W+1)'(deadzone));
    y_pos = !axis_y[AXIS_W-1] && (y_mag > (AXIS_W+1)'(deadzone));
    dir = DIR_NEUTRAL
        + (x_pos ? DIR_STEP_X : '0) - (x_neg ? DIR_STEP_X : '0)
        + (y_pos ? DIR_STEP_Y : '0) - (y_neg ? DIR_STEP_Y : '0);
  end

  // Held time accumulate with saturation and repeat decision
  always_comb begin
    held_sum  = {1'b0, held_time} + (HELD_W+1)'(elapsed_ticks);
    held_sat  = held_sum[HELD_W] ? '1 : held_sum[HELD_W-1:0];
    threshold = repeating ? repeat_interval : first_delay;
    if (dir != last_direction) begin
      press          = 1'b1;
      repeating_next = 1'b0;
    end else begin
      press          = held_sat > HELD_W'(threshold);
      repeating_next = repeating || press;
    end
    held_time_next = press ? '0 : held_sat;

    result_next.direction_code = dir;
    result_next.press_event    = press;
    result_next.left_held      = x_neg;
    result_next.right_held     = x_pos;
    result_next.up_held        = y_pos;
    result_next.down_held      = y_neg;
    result_next.left_event     = press && x_neg;
    result_next.right_event    = press && x_pos;
    result_next.up_event       = press && y_pos;
    result_next.down_event     = press && y_neg;
  end

  // State advances once per sample, as the result is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      held_time      <= '0;
      repeating      <= 1'b0;
      last_direction <= DIR_NEUTRAL;
    end else if (out_load) begin
      held_time      <= held_time_next;
      repeating      <= repeating_next;
      last_direction <= dir;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= result_next;
    end
  end

  assign m_tdata = {(OUT_TDATA_W - $bits(result_t))'(0), result};

  // Checks
  `SDA_ASSERT_NEXT(a_change_fires, clk, rst, out_load && (dir != last_direction), m_tvalid && result.press_event)
  `SDA_ASSERT_NEXT(a_event_clears_time, clk, rst, out_load && press, held_time == '0)
  `SDA_ASSERT_NOW(a_no_opposite_dirs, clk, rst, m_tvalid, !(result.left_held && result.right_held) && !(result.up_held && result.down_held))
  `SDA_ASSERT_NOW(a_dir_event_needs_press, clk, rst, m_tvalid && (result.left_event || result.right_event || result.up_event || result.down_event), result.press_event)
  `SDA_ASSERT_NOW(a_reset_neutral, clk, rst, $past(rst), last_direction == DIR_NEUTRAL && !repeating)

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import stkdir_pkg::*;

  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 155;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 300;
  localparam int LONG_HOLD_AT   = 400;
  localparam int MAX_REPORTS    = 10;
  // Index past the register list; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // [15:0] axis_x, [31:16] axis_y, [47:32] elapsed_ticks
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // [3:0] direction_code, [4] press_event, [8:5] left/right/up/down held,
  // [12:9] left/right/up/down event, [15:13] zero
  logic [OUT_TDATA_W-1:0] m_tdata;

  stick_direction_autorepeat_core DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state and register copies
  logic [DEADZONE_W-1:0] dz_reg = DEADZONE_RST;
  logic [DELAY_W-1:0]    first_delay_reg = FIRST_DELAY_RST;
  logic [DELAY_W-1:0]    repeat_reg = REPEAT_INTERVAL_RST;
  logic [HELD_W-1:0]     held_ticks = '0;
  logic                  repeat_armed = 1'b0;
  logic [DIR_W-1:0]      prev_dir = DIR_NEUTRAL;

  result_t pending_results[$];
  int      errors = 0;
  int      samples_sent = 0;
  int      rx_count = 0;
  int      press_events = 0;
  logic [15:0] codes_seen = '0;
  int      burst_left = 0;

  // Deflection of one axis after the deadzone test: -1, 0 or +1
  function automatic int deflection(input logic signed [AXIS_W-1:0] v);
    int mag;
    mag = (v < 0) ? -int'(v) : int'(v);
    if (mag <= int'(dz_reg)) return 0;
    return (v < 0) ? -1 : 1;
  endfunction

  // Direction decode plus typematic timing for one sample
  function automatic result_t stick_step(input logic signed [AXIS_W-1:0] ax,
                                         input logic signed [AXIS_W-1:0] ay,
                                         input logic [TICKS_W-1:0] dt);
    result_t r;
    int code;
    logic [DIR_W-1:0] dir;
    logic [HELD_W:0] sum;
    logic ev;
    code = int'(DIR_NEUTRAL) + deflection(ax) * int'(DIR_STEP_X)
         + deflection(ay) * int'(DIR_STEP_Y);
    dir = code[DIR_W-1:0];
    if (dir != prev_dir) begin
      repeat_armed = 1'b0;
      ev = 1'b1;
    end else begin
      sum = {1'b0, held_ticks} + (HELD_W+1)'(dt);
      held_ticks = sum[HELD_W] ? '1 : sum[HELD_W-1:0];
      if (repeat_armed) begin
        ev = held_ticks > repeat_reg;
      end else begin
        ev = held_ticks > first_delay_reg;
        repeat_armed = ev;
      end
    end
    if (ev) held_ticks = '0;
    prev_dir = dir;
    r.direction_code = dir;
    r.press_event = ev;
    r.left_held = (dir % 3) == 1;
    r.right_held = (dir % 3) == 0;
    r.up_held = dir > 6;
    r.down_held = dir < 4;
    r.left_event = ev & r.left_held;
    r.right_event = ev & r.right_held;
    r.up_event = ev & r.up_held;
    r.down_event = ev & r.down_held;
    return r;
  endfunction

  // Sender gap: mostly back to back, some short, a few long, with bursts
  function automatic int next_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Axis sample for a wanted deflection, often right at the deadzone edge
  function automatic logic signed [AXIS_W-1:0] axis_sample(input int s);
    int m;
    int dz;
    dz = int'(dz_reg);
    if (s == 0 || (s > 0 && dz == 32767)) begin
      m = ($urandom_range(0, 3) == 0) ? dz : $urandom_range(0, dz);
      return ($urandom_range(0, 1) != 0) ? AXIS_W'(m) : AXIS_W'(-m);
    end
    if (s > 0) begin
      m = ($urandom_range(0, 3) == 0) ? dz + 1 : $urandom_range(dz + 1, 32767);
      return AXIS_W'(m);
    end
    m = ($urandom_range(0, 3) == 0) ? dz + 1 : $urandom_range(dz + 1, 32768);
    return AXIS_W'(-m);
  endfunction

  function automatic logic [TICKS_W-1:0] tick_sample(input int lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 15) return '1;
    if (r < 30) return TICKS_W'($urandom);
    return TICKS_W'($urandom_range(0, lim));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_DEADZONE:        dz_reg = val[DEADZONE_W-1:0];
      CFG_FIRST_DELAY:     first_delay_reg = val;
      CFG_REPEAT_INTERVAL: repeat_reg = val;
      default: ;
    endcase
  endtask

  // One sample transfer; fixed rows override code and event with typed values
  task automatic send_sample(input logic signed [AXIS_W-1:0] ax,
                             input logic signed [AXIS_W-1:0] ay,
                             input logic [TICKS_W-1:0] dt,
                             input bit fixed, input logic [DIR_W-1:0] fcode,
                             input bit fev);
    int gap;
    result_t r;
    gap = next_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= {dt, ay, ax};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    r = stick_step(ax, ay, dt);
    if (fixed) begin
      r.direction_code = fcode;
      r.press_event = fev;
    end
    pending_results.push_back(r);
    samples_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  typedef struct {
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic [TICKS_W-1:0]       ticks;
    bit                       fixed;
    logic [DIR_W-1:0]         code;
    bit                       ev;
  } probe_row_t;

  // Reset registers: deadzone 7849, first delay 500, repeat 250
  probe_row_t probes[] = '{
    '{16'sd0,      16'sd0,      16'd0,     1, 4'd5, 0}, // neutral after reset
    '{16'sd32767,  16'sd0,      16'd0,     1, 4'd6, 1}, // full right
    '{-16'sd32768, -16'sd32768, 16'd7,     1, 4'd1, 1}, // most negative on both
    '{16'sd7849,   16'sd0,      16'd3,     1, 4'd5, 1}, // at deadzone: not deflected
    '{16'sd7850,   16'sd0,      16'd3,     1, 4'd6, 1}, // one past deadzone
    '{-16'sd7849,  -16'sd7849,  16'd0,     1, 4'd5, 1},
    '{-16'sd7850,  16'sd0,      16'd0,     1, 4'd4, 1},
    '{16'sd0,      16'sd7850,   16'd0,     1, 4'd8, 1},
    '{16'sd0,      -16'sd7850,  16'd0,     1, 4'd2, 1},
    '{16'sd7850,   16'sd7850,   16'd0,     1, 4'd9, 1},
    '{-16'sd7850,  16'sd7850,   16'd0,     1, 4'd7, 1},
    '{16'sd7850,   -16'sd7850,  16'd0,     1, 4'd3, 1},
    '{16'sd32767,  -16'sd32768, 16'd500,   1, 4'd3, 0}, // held exactly first delay
    '{16'sd20000,  -16'sd20000, 16'd1,     1, 4'd3, 1}, // first repeat
    '{16'sd20000,  -16'sd20000, 16'd250,   1, 4'd3, 0}, // exactly repeat interval
    '{16'sd20000,  -16'sd20000, 16'd1,     1, 4'd3, 1},
    '{16'sd20000,  -16'sd20000, 16'hFFFF,  1, 4'd3, 1},
    '{-16'sd32768, 16'sd32767,  16'hFFFF,  1, 4'd7, 1}, // change drops the ticks
    '{-16'sd32768, 16'sd32767,  16'hFFFF,  1, 4'd7, 1},
    '{16'sd0,      16'sd0,      16'd100,   1, 4'd5, 1},
    '{16'sd100,    -16'sd100,   16'hFFFF,  1, 4'd5, 1}, // neutral repeats too
    '{-16'sd1,     16'sd1,      16'hFFFF,  1, 4'd5, 1},
    '{16'sd0,      16'sd0,      16'd0,     1, 4'd5, 0},
    '{-16'sd32768, 16'sd0,      16'hFFFF,  1, 4'd4, 1}
  };

  // Stimulus
  initial begin
    int ph;
    int k;
    int run_len;
    int sx;
    int sy;
    int lim;
    int sent;
    logic [DEADZONE_W-1:0] dz;
    logic [DELAY_W-1:0] fd;
    logic [DELAY_W-1:0] ri;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Spare index must leave every register alone
    write_reg(CFG_SPARE, '0);
    cfg_wr_en <= 1'b0;
    foreach (probes[i])
      send_sample(probes[i].x, probes[i].y, probes[i].ticks,
                  probes[i].fixed, probes[i].code, probes[i].ev);
    drain();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin dz = '0; fd = '0; ri = '0; end
        1: begin dz = '1; fd = '1; ri = '1; end
        2: begin dz = DEADZONE_RST; fd = FIRST_DELAY_RST; ri = REPEAT_INTERVAL_RST; end
        7: begin
          dz = DEADZONE_W'($urandom_range(0, 20000));
          fd = DELAY_W'($urandom_range(0, 100));
          ri = '1;
        end
        default: begin
          dz = DEADZONE_W'($urandom_range(0, 32767));
          fd = DELAY_W'($urandom_range(0, 3000));
          ri = DELAY_W'($urandom_range(0, 1500));
        end
      endcase
      write_reg(CFG_DEADZONE, {9'($urandom), dz});
      write_reg(CFG_FIRST_DELAY, fd);
      write_reg(CFG_REPEAT_INTERVAL, ri);
      if (ph == 2) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
      cfg_wr_en <= 1'b0;
      lim = ((fd > ri) ? int'(fd) : int'(ri)) / 3 + 2;
      if (lim > 65535) lim = 65535;

      // Mostly held directions with random content, some raw noise
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 15) begin
          send_sample(AXIS_W'($urandom), AXIS_W'($urandom), TICKS_W'($urandom),
                      0, '0, 0);
          sent++;
        end else begin
          sx = int'($urandom_range(0, 2)) - 1;
          sy = int'($urandom_range(0, 2)) - 1;
          run_len = $urandom_range(1, 30);
          for (k = 0; k < run_len && sent < PHASE_ITEMS; k++) begin
            send_sample(axis_sample(sx), axis_sample(sy), tick_sample(lim), 0, '0, 0);
            sent++;
          end
        end
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("summary: %0d samples over %0d register settings, %0d results checked",
             samples_sent, NUM_PHASES + 1, rx_count);
    $display("summary: %0d press events, %0d of 9 direction codes seen, %0d errors",
             press_events, $countones(codes_seen), errors);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Receiver readiness: random stalls, steady stretches, one long hold-off
  int  hold_left = 0;
  int  steady_left = 0;
  bit  long_hold_done = 1'b0;
  always @(posedge clk) begin : rx_ready
    int r;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (!long_hold_done && rx_count >= LONG_HOLD_AT) begin
      long_hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (steady_left > 0) begin
      steady_left <= steady_left - 1;
      m_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        hold_left <= (r == 0) ? $urandom_range(15, 50) : $urandom_range(0, 3);
        m_tready <= 1'b0;
      end else if (r < 14) begin
        steady_left <= $urandom_range(20, 80);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Result check against the oldest pending expectation
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[12:0]);
      rx_count <= rx_count + 1;
      codes_seen[got.direction_code] <= 1'b1;
      if (got.press_event) press_events++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result transfer: m_tdata %h", m_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got !== want || m_tdata[15:13] !== 3'b000) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display({"mismatch at result %0d: code %0d/%0d event %b/%b ",
                      "held lrud %b/%b events lrud %b/%b pad %b (exp/act)"},
                     rx_count, want.direction_code, got.direction_code,
                     want.press_event, got.press_event,
                     {want.left_held, want.right_held, want.up_held, want.down_held},
                     {got.left_held, got.right_held, got.up_held, got.down_held},
                     {want.left_event, want.right_event, want.up_event, want.down_event},
                     {got.left_event, got.right_event, got.up_event, got.down_event},
                     m_tdata[15:13]);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending",
               idle_cycles, pending_results.size());
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
